[src/riscv_immediate_alu_executor_unit_defines.svh]
// assertion macros shared by the executor rtl
`ifndef RISCV_IMMEDIATE_ALU_EXECUTOR_UNIT_DEFINES_SVH
`define RISCV_IMMEDIATE_ALU_EXECUTOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define RIE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define RIE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rie_pkg.sv]
// shared types and constants of the immediate alu executor
`timescale 1ns / 1ps

package rie_pkg;

    localparam int unsigned XLEN     = 32;
    localparam int unsigned REG_AW   = 5;
    localparam int unsigned REG_NUM  = 32;

    localparam logic [6:0]      OPC_IMM     = 7'h13;
    localparam logic [XLEN-1:0] EBREAK_WORD = 32'h0010_0073;
    localparam logic [XLEN-1:0] PC_STEP     = 32'd4;

    // abi registers: zero, and a0 and a1 used by the environment call
    localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
    localparam logic [REG_AW-1:0] REG_A0   = 5'd10;
    localparam logic [REG_AW-1:0] REG_A1   = 5'd11;

    // funct3 codes under the immediate opcode
    localparam logic [2:0] FN3_ADDI = 3'd0;
    localparam logic [2:0] FN3_XORI = 3'd4;
    localparam logic [2:0] FN3_ORI  = 3'd6;
    localparam logic [2:0] FN3_ANDI = 3'd7;

    // environment call commands held in a0
    localparam logic [XLEN-1:0] CMD_PUTCHAR = 32'd0;
    localparam logic [XLEN-1:0] CMD_HALT    = 32'd1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_CHAR       = 3'd1,
        ST_HALT       = 3'd2,
        ST_BAD_FN3    = 3'd3,
        ST_BAD_EBREAK = 3'd4,
        ST_BAD_INSTR  = 3'd5,
        ST_IGNORED    = 3'd6
    } t_status;

    // register file write request
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } t_rf_wr;

endpackage

[src/rie_regfile.sv]
// register file: synchronous two-read one-write memory with valid bits and bypass
`timescale 1ns / 1ps

module rie_regfile (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rd_en,
    input  logic [rie_pkg::REG_AW-1:0]      i_rd_addr_a,
    input  logic [rie_pkg::REG_AW-1:0]      i_rd_addr_b,
    output logic [rie_pkg::XLEN-1:0]        o_rd_data_a,
    output logic [rie_pkg::XLEN-1:0]        o_rd_data_b,
    input  rie_pkg::t_rf_wr                 i_wr
);

    logic [rie_pkg::XLEN-1:0]    mem [rie_pkg::REG_NUM];
    logic [rie_pkg::REG_NUM-1:0] r_valid;

    logic [rie_pkg::XLEN-1:0]    r_dat_a;
    logic [rie_pkg::XLEN-1:0]    r_dat_b;
    logic                        r_vld_a;
    logic                        r_vld_b;
    logic [rie_pkg::REG_AW-1:0]  r_addr_a;
    logic [rie_pkg::REG_AW-1:0]  r_addr_b;
    rie_pkg::t_rf_wr             r_byp;

    // memory write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_dat_a  <= mem[i_rd_addr_a];
            r_dat_b  <= mem[i_rd_addr_b];
            r_addr_a <= i_rd_addr_a;
            r_addr_b <= i_rd_addr_b;
        end
    end

    // valid bits: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_vld_a <= r_valid[i_rd_addr_a];
                r_vld_b <= r_valid[i_rd_addr_b];
            end
        end
    end

    // bypass keeps the latest write, covers a read taken at the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp.en <= 1'b0;
        end else if (i_wr.en) begin
            r_byp <= i_wr;
        end
    end

    // read data selection
    always_comb begin
        if (r_byp.en && (r_byp.addr == r_addr_a)) begin
            o_rd_data_a = r_byp.data;
        end else begin
            o_rd_data_a = r_vld_a ? r_dat_a : '0;
        end
        if (r_byp.en && (r_byp.addr == r_addr_b)) begin
            o_rd_data_b = r_byp.data;
        end else begin
            o_rd_data_b = r_vld_b ? r_dat_b : '0;
        end
    end

endmodule

[src/riscv_immediate_alu_executor_unit.sv]
// top level: immediate alu executor with register file, pc and halt flag
//
//  channel  direction  valid          stall          payload
//  in       to block   i_in_valid     o_in_stall     i_instruction
//  out      from block o_out_valid    i_out_stall    o_next_pc, o_status, o_char_byte
//
// one item per cycle sustained while the output is not stalled; the register file
// memory is read as an item is accepted, then the execute stage executes, writes back and
// loads the output register; a write-back bypass resolves back-to-back hazards
// reset is synchronous, clears pc, halt flag and register file valid bits
// a stalled output holds the execute stage, which then stalls the input
`timescale 1ns / 1ps
`include "riscv_immediate_alu_executor_unit_defines.svh"

module riscv_immediate_alu_executor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_instruction,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_next_pc,
    output logic [2:0]  o_status,
    output logic [7:0]  o_char_byte
);

    logic                            r_s1_valid;
    logic [rie_pkg::XLEN-1:0]        r_instr;
    logic [rie_pkg::XLEN-1:0]        r_pc;
    logic                            r_halted;
    logic                            r_out_valid;
    logic [rie_pkg::XLEN-1:0]        r_out_pc;
    rie_pkg::t_status                r_out_status;
    logic [7:0]                      r_out_char;

    logic                            in_accept;
    logic                            out_ready;
    logic                            fire;
    logic                            in_is_ebreak;
    logic [rie_pkg::REG_AW-1:0]      rd_addr_a;
    logic [rie_pkg::XLEN-1:0]        rd_data_a;
    logic [rie_pkg::XLEN-1:0]        rd_data_b;
    rie_pkg::t_rf_wr                 rf_wr;

    logic                            is_imm;
    logic                            is_ebreak;
    logic [rie_pkg::REG_AW-1:0]      rd;
    logic [2:0]                      fn3;
    logic [rie_pkg::XLEN-1:0]        imm;
    logic [rie_pkg::XLEN-1:0]        alu_res;
    logic                            alu_ok;
    logic [rie_pkg::XLEN-1:0]        n_pc;
    logic                            n_halted;
    rie_pkg::t_status                n_status;
    logic [7:0]                      n_char;

    // handshake
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign fire       = r_s1_valid && out_ready;
    assign o_in_stall = r_s1_valid && !out_ready;
    assign in_accept  = i_in_valid && !o_in_stall;

    // read addresses: rs1, or a0 and a1 for the environment call
    assign in_is_ebreak = (i_instruction == rie_pkg::EBREAK_WORD);
    assign rd_addr_a    = in_is_ebreak ? rie_pkg::REG_A0 : i_instruction[19:15];

    rie_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_accept),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rie_pkg::REG_A1),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b),
        .i_wr        (rf_wr)
    );

    // execute stage holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_instr <= i_instruction;
        end
    end

    // decode
    assign is_imm    = (r_instr[6:0] == rie_pkg::OPC_IMM);
    assign is_ebreak = (r_instr == rie_pkg::EBREAK_WORD);
    assign rd        = r_instr[11:7];
    assign fn3       = r_instr[14:12];
    assign imm       = {{(rie_pkg::XLEN-12){r_instr[31]}}, r_instr[31:20]};

    // immediate alu
    always_comb begin
        alu_ok  = 1'b1;
        alu_res = '0;
        unique case (fn3)
            rie_pkg::FN3_ADDI: alu_res = rd_data_a + imm;
            rie_pkg::FN3_XORI: alu_res = rd_data_a ^ imm;
            rie_pkg::FN3_ORI:  alu_res = rd_data_a | imm;
            rie_pkg::FN3_ANDI: alu_res = rd_data_a & imm;
            default:           alu_ok  = 1'b0;
        endcase
    end

    // status, next pc, halt and write-back
    always_comb begin
        n_status = rie_pkg::ST_OK;
        n_char   = '0;
        n_pc     = r_pc + rie_pkg::PC_STEP;
        n_halted = r_halted;
        rf_wr    = '0;
        if (r_halted) begin
            n_status = rie_pkg::ST_IGNORED;
            n_pc     = r_pc;
        end else if (is_imm) begin
            if (alu_ok) begin
                rf_wr.en   = fire && (rd != rie_pkg::REG_ZERO);
                rf_wr.addr = rd;
                rf_wr.data = alu_res;
            end else begin
                n_status = rie_pkg::ST_BAD_FN3;
            end
        end else if (is_ebreak) begin
            if (rd_data_a == rie_pkg::CMD_PUTCHAR) begin
                n_status = rie_pkg::ST_CHAR;
                n_char   = rd_data_b[7:0];
            end else if (rd_data_a == rie_pkg::CMD_HALT) begin
                n_status = rie_pkg::ST_HALT;
                n_halted = 1'b1;
            end else begin
                n_status = rie_pkg::ST_BAD_EBREAK;
            end
        end else begin
            n_status = rie_pkg::ST_BAD_INSTR;
        end
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= '0;
            r_halted <= 1'b0;
        end else if (fire) begin
            r_pc     <= n_pc;
            r_halted <= n_halted;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_pc     <= n_pc;
            r_out_status <= n_status;
            r_out_char   <= n_char;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_next_pc   = r_out_pc;
    assign o_status    = r_out_status;
    assign o_char_byte = r_out_char;

    // checks
    `RIE_ASSERT_NXT(a_halt_sticky, i_clk, i_rst_n, r_halted, r_halted, "halt flag cleared")
    `RIE_ASSERT_IMP(a_ignored_pc, i_clk, i_rst_n, o_out_valid && (o_status == rie_pkg::ST_IGNORED), o_next_pc == r_pc, "ignored item moved pc")
    `RIE_ASSERT_IMP(a_no_x0_write, i_clk, i_rst_n, rf_wr.en, (rf_wr.addr != rie_pkg::REG_ZERO) && !r_halted, "bad register write")
    `RIE_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, r_s1_valid && r_out_valid && i_out_stall, "input stalled without cause")

endmodule

[test/riscv_immediate_alu_executor_unit_tb.sv]
// self-checking testbench for the immediate alu executor unit
`timescale 1ns / 1ps

module riscv_immediate_alu_executor_unit_tb;

    import rie_pkg::*;

    localparam int IDLE_LIMIT    = 1000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int RANDOM_TARGET = 1590;
    localparam int HOLD_AT_ITEM  = 500;
    localparam int HOLD_CYCLES   = 64;

    typedef struct packed {
        logic [31:0] next_pc;
        t_status     status;
        logic [7:0]  char_byte;
    } exec_result_t;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_MOST,
        STALL_EVERY_THIRD
    } stall_mode_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [31:0] i_instruction = '0;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_next_pc;
    logic [2:0]  o_status;
    logic [7:0]  o_char_byte;

    // architectural state of the core as the testbench sees it
    logic [31:0] shadow_regs [32];
    logic [31:0] shadow_pc     = '0;
    logic        shadow_halted = 1'b0;

    logic [31:0]  pending_items [$];
    exec_result_t expected_results [$];

    logic in_fire        = 1'b0;
    int   accepted_count = 0;
    int   total_items    = 0;
    int   mismatch_count = 0;

    riscv_immediate_alu_executor_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_instruction (i_instruction),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_next_pc     (o_next_pc),
        .o_status      (o_status),
        .o_char_byte   (o_char_byte)
    );

    always #5 i_clk = ~i_clk;

    // i-type word under the immediate opcode
    function automatic logic [31:0] encode_imm_op(input logic [2:0] fn3, input logic [4:0] rd,
                                                  input logic [4:0] rs1, input logic [11:0] imm);
        return {imm, rs1, fn3, rd, OPC_IMM};
    endfunction

    function automatic bit is_alu_fn3(input logic [2:0] fn3);
        return fn3 == FN3_ADDI || fn3 == FN3_XORI || fn3 == FN3_ORI || fn3 == FN3_ANDI;
    endfunction

    function automatic logic [2:0] pick_alu_fn3();
        case ($urandom_range(0, 3))
            0: return FN3_ADDI;
            1: return FN3_XORI;
            2: return FN3_ORI;
            default: return FN3_ANDI;
        endcase
    endfunction

    // immediates lean toward the sign-extension corners
    function automatic logic [11:0] random_imm12();
        case ($urandom_range(0, 7))
            0: return 12'h000;
            1: return 12'h7ff;
            2: return 12'h800;
            3: return 12'hfff;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    // executes one instruction on the shadow state and queues its result
    function automatic void execute_instruction(input logic [31:0] word);
        exec_result_t res;
        logic [31:0]  src;
        logic [31:0]  imm;
        logic [31:0]  alu;
        logic         wr_en;
        res.status    = ST_OK;
        res.char_byte = '0;
        if (shadow_halted) begin
            res.next_pc = shadow_pc;
            res.status  = ST_IGNORED;
        end else begin
            if (word[6:0] == OPC_IMM) begin
                src   = shadow_regs[word[19:15]];
                imm   = {{20{word[31]}}, word[31:20]};
                wr_en = 1'b1;
                alu   = '0;
                case (word[14:12])
                    FN3_ADDI: alu = src + imm;
                    FN3_XORI: alu = src ^ imm;
                    FN3_ORI:  alu = src | imm;
                    FN3_ANDI: alu = src & imm;
                    default: begin
                        wr_en      = 1'b0;
                        res.status = ST_BAD_FN3;
                    end
                endcase
                if (wr_en && word[11:7] != REG_ZERO) begin
                    shadow_regs[word[11:7]] = alu;
                end
            end else if (word == EBREAK_WORD) begin
                if (shadow_regs[REG_A0] == CMD_PUTCHAR) begin
                    res.status    = ST_CHAR;
                    res.char_byte = shadow_regs[REG_A1][7:0];
                end else if (shadow_regs[REG_A0] == CMD_HALT) begin
                    res.status    = ST_HALT;
                    shadow_halted = 1'b1;
                end else begin
                    res.status = ST_BAD_EBREAK;
                end
            end else begin
                res.status = ST_BAD_INSTR;
            end
            shadow_pc   = shadow_pc + PC_STEP;
            res.next_pc = shadow_pc;
        end
        expected_results.push_back(res);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // putchar call, or now and then a bad command, with a0 set right before the ebreak, so a0 is always known
    task automatic push_putchar_sequence();
        logic [11:0] cmd;
        if ($urandom_range(0, 1)) begin
            pending_items.push_back(encode_imm_op(pick_alu_fn3(), REG_A1,
                                                  5'($urandom_range(0, 31)), random_imm12()));
        end
        if ($urandom_range(0, 3) != 0) begin
            cmd = 12'(CMD_PUTCHAR);
        end else begin
            do cmd = 12'($urandom_range(0, 4095)); while (cmd == 12'(CMD_HALT));
        end
        pending_items.push_back(encode_imm_op(FN3_ADDI, REG_A0, REG_ZERO, cmd));
        pending_items.push_back(EBREAK_WORD);
    endtask

    // stimulus: directed items, random mix, then a halt with items after it
    initial begin : stimulus
        logic [31:0] word;
        logic [2:0]  fn3;
        int          pick;
        foreach (shadow_regs[k]) shadow_regs[k] = '0;

        // sign-extension extremes and every alu operation
        pending_items.push_back(encode_imm_op(FN3_ADDI, 5'd1, REG_ZERO, 12'h7ff));
        pending_items.push_back(encode_imm_op(FN3_ADDI, 5'd2, REG_ZERO, 12'h800));
        pending_items.push_back(encode_imm_op(FN3_ADDI, 5'd3, 5'd2, 12'hfff));
        pending_items.push_back(encode_imm_op(FN3_XORI, 5'd4, 5'd1, 12'h800));
        pending_items.push_back(encode_imm_op(FN3_ORI, 5'd5, 5'd2, 12'h555));
        pending_items.push_back(encode_imm_op(FN3_ANDI, 5'd6, 5'd3, 12'haaa));
        // write to x0 is dropped, then x0 is read back
        pending_items.push_back(encode_imm_op(FN3_ADDI, REG_ZERO, 5'd1, 12'h005));
        pending_items.push_back(encode_imm_op(FN3_ORI, 5'd31, REG_ZERO, 12'h000));
        // every unsupported funct3
        for (int f = 0; f < 8; f++) begin
            if (!is_alu_fn3(3'(f))) begin
                pending_items.push_back(encode_imm_op(3'(f), 5'd7, 5'd1, 12'h123));
            end
        end
        // putchar with printable and all-ones bytes, then a bad command
        pending_items.push_back(encode_imm_op(FN3_ADDI, REG_A1, REG_ZERO, 12'h041));
        pending_items.push_back(encode_imm_op(FN3_ADDI, REG_A0, REG_ZERO, 12'(CMD_PUTCHAR)));
        pending_items.push_back(EBREAK_WORD);
        pending_items.push_back(encode_imm_op(FN3_ADDI, REG_A1, REG_ZERO, 12'hfff));
        pending_items.push_back(EBREAK_WORD);
        pending_items.push_back(encode_imm_op(FN3_ADDI, REG_A0, REG_ZERO, 12'h002));
        pending_items.push_back(EBREAK_WORD);
        // unsupported words
        pending_items.push_back(32'h0000_0000);
        pending_items.push_back(32'hffff_ffff);
        pending_items.push_back(32'h0000_0073);

        // random mix, mostly well-formed alu work
        while (pending_items.size() < RANDOM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                pending_items.push_back(encode_imm_op(pick_alu_fn3(), 5'($urandom_range(0, 31)),
                                                      5'($urandom_range(0, 31)),
                                                      random_imm12()));
            end else if (pick < 65) begin
                do fn3 = 3'($urandom_range(0, 7)); while (is_alu_fn3(fn3));
                pending_items.push_back(encode_imm_op(fn3, 5'($urandom_range(0, 31)),
                                                      5'($urandom_range(0, 31)),
                                                      random_imm12()));
            end else if (pick < 77) begin
                push_putchar_sequence();
            end else if (pick < 85) begin
                do word = $urandom; while (word[6:0] == OPC_IMM || word == EBREAK_WORD);
                pending_items.push_back(word);
            end else if (pick < 90) begin
                // one bit off the ebreak word, opcode untouched
                pending_items.push_back(EBREAK_WORD ^ (32'h1 << $urandom_range(7, 31)));
            end else begin
                do word = $urandom; while (word == EBREAK_WORD);
                pending_items.push_back(word);
            end
        end

        // halt, then items that must be ignored
        pending_items.push_back(encode_imm_op(FN3_ADDI, REG_A0, REG_ZERO, 12'(CMD_HALT)));
        pending_items.push_back(EBREAK_WORD);
        pending_items.push_back(encode_imm_op(FN3_ADDI, 5'd1, REG_ZERO, 12'h001));
        pending_items.push_back(EBREAK_WORD);
        pending_items.push_back(32'hffff_ffff);
        total_items = pending_items.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_items || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // item driver: bursts of random length with random gaps
    always @(negedge i_clk) begin : item_driver
        int burst_left;
        int gap_left;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = $urandom_range(1, 40);
            gap_left   = 0;
        end else if (!i_in_valid || in_fire) begin
            if (gap_left > 0 || pending_items.size() == 0) begin
                if (gap_left > 0) gap_left--;
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid    <= 1'b1;
                i_instruction <= pending_items.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // result receiver: changing stall pattern plus one long hold-off
    always @(negedge i_clk) begin : result_receiver
        stall_mode_t mode;
        int          mode_left;
        int          phase;
        int          hold_left;
        bit          hold_done;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            mode_left = 0;
            phase     = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            if (!hold_done && accepted_count >= HOLD_AT_ITEM) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 150);
                end
                mode_left--;
                phase++;
                case (mode)
                    STALL_NONE: i_out_stall <= 1'b0;
                    STALL_HALF: i_out_stall <= 1'($urandom_range(0, 1));
                    STALL_MOST: i_out_stall <= ($urandom_range(0, 7) != 0);
                    default:    i_out_stall <= (phase % 3 == 0);
                endcase
            end
        end
    end

    // monitor: predicts on each accepted item, checks each accepted result
    always @(posedge i_clk) begin : result_monitor
        exec_result_t want;
        in_fire <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            execute_instruction(i_instruction);
            accepted_count++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending, next_pc", o_next_pc, '0);
            end else begin
                want = expected_results.pop_front();
                if (o_next_pc !== want.next_pc) begin
                    report_mismatch("next_pc", o_next_pc, want.next_pc);
                end
                if (o_status !== want.status) begin
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                end
                if (o_char_byte !== want.char_byte) begin
                    report_mismatch("char_byte", 32'(o_char_byte), 32'(want.char_byte));
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin : watchdog
        int idle_cycles;
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ns: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule
